[rtl/rrd_pkg.sv]
// ----------------------------------------------------------------------------
// rrd_pkg
// types, constants and codes shared by the raster row run-length decoder
// ----------------------------------------------------------------------------
package rrd_pkg;

   localparam int MAX_ROW_BYTES = 512;
   localparam int MAX_PATTERN   = 16;
   localparam int ROW_W         = 10;
   localparam int PLEN_W        = 5;
   localparam int PIDX_W        = 4;
   localparam int WORD_BYTES    = 8;

   localparam logic [0:0] CSR_ROW_LENGTH     = 1'd0;
   localparam logic [0:0] CSR_PATTERN_LENGTH = 1'd1;

   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_ZERO     = 3'd1;
   localparam logic [2:0] ERR_OVERRUN  = 3'd2;
   localparam logic [2:0] ERR_VERTICAL = 3'd3;
   localparam logic [2:0] ERR_TRUNC    = 3'd4;

   localparam logic [7:0] LEAD_LITERAL = 8'h80;
   localparam logic [7:0] LEAD_PATTERN = 8'h00;

   typedef enum logic [2:0] {
      PH_LEAD,
      PH_LIT_COUNT,
      PH_LIT_DATA,
      PH_PAT_COUNT,
      PH_PAT_DATA
   } phase_type;

   typedef struct packed {
      logic [7:0] enc_byte;
      logic       end_of_data;
   } req_type;

   typedef struct packed {
      logic [63:0] out_bytes;
      logic [3:0]  byte_count;
      logic        row_done;
      logic [2:0]  error_code;
      logic        last_of_run;
   } rsp_type;

   // one run (or one error) handed from the parser to the expander
   typedef struct packed {
      logic [2:0]                 err;
      logic [ROW_W-1:0]           total;
      logic [ROW_W-1:0]           start_pos;
      logic [ROW_W-1:0]           rlen;
      logic [PLEN_W-1:0]          plen;
      logic [MAX_PATTERN*8-1:0]   pattern;
   } cmd_type;

endpackage

[rtl/rrd_front.sv]
// ----------------------------------------------------------------------------
// rrd_front
// parses encoded bytes, tracks the row and issues run commands
// ----------------------------------------------------------------------------
module rrd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  rrd_pkg::req_type      req_item,
   output logic                  req_full,
   input  logic [9:0]            row_length,
   input  logic [4:0]            pattern_length,
   output logic                  cmd_push,
   output rrd_pkg::cmd_type      cmd,
   input  logic                  cmd_full
);
   import rrd_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [ROW_W-1:0]   pos_ff, pos_in;
   logic [7:0]         rem_ff, rem_in;
   logic [7:0]         rep_ff, rep_in;
   logic [PLEN_W-1:0]  fill_ff, fill_in;
   logic [7:0]         store_ff [MAX_PATTERN];

   logic [ROW_W-1:0]   rlen;
   logic [PLEN_W-1:0]  plen;
   logic               acc;
   logic               emit;
   logic [2:0]         err;
   logic [12:0]        total_w;
   logic [12:0]        pos_after;
   logic [PLEN_W-1:0]  emit_plen;
   logic [MAX_PATTERN*8-1:0] pat_now;
   logic [MAX_PATTERN*8-1:0] emit_pat;
   logic [7:0]         b;

   always_comb begin
      rlen = row_length;
      if (row_length == '0) rlen = ROW_W'(1);
      if (row_length > ROW_W'(MAX_ROW_BYTES)) rlen = ROW_W'(MAX_ROW_BYTES);
      plen = pattern_length;
      if (pattern_length == '0) plen = PLEN_W'(1);
      if (pattern_length > PLEN_W'(MAX_PATTERN)) plen = PLEN_W'(MAX_PATTERN);
   end

   assign acc      = req_push && !cmd_full;
   assign req_full = cmd_full;
   assign b        = req_item.enc_byte;

   always_comb begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
         pat_now[i*8 +: 8] = store_ff[i];
      end
      pat_now[fill_ff[PIDX_W-1:0]*8 +: 8] = b;
   end

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      rem_in    = rem_ff;
      rep_in    = rep_ff;
      fill_in   = fill_ff;
      emit      = 1'b0;
      err       = ERR_NONE;
      total_w   = '0;
      emit_plen = PLEN_W'(1);
      emit_pat  = {MAX_PATTERN{b}};
      case (phase_ff)
         PH_LEAD: begin
            if (b == LEAD_LITERAL) begin
               phase_in = PH_LIT_COUNT;
            end else if (b == LEAD_PATTERN) begin
               phase_in = PH_PAT_COUNT;
            end else begin
               total_w  = {6'd0, b[6:0]};
               emit_pat = {MAX_PATTERN{{8{b[7]}}}};
               if (13'(pos_ff) + total_w > 13'(rlen)) err = ERR_OVERRUN;
               else emit = 1'b1;
            end
         end
         PH_LIT_COUNT: begin
            if (b == 8'd0) err = ERR_ZERO;
            else if (13'(pos_ff) + 13'(b) > 13'(rlen)) err = ERR_OVERRUN;
            else begin
               rem_in   = b;
               phase_in = PH_LIT_DATA;
            end
         end
         PH_LIT_DATA: begin
            total_w = 13'd1;
            if (13'(pos_ff) + 13'd1 > 13'(rlen)) err = ERR_OVERRUN;
            else begin
               emit = 1'b1;
               if (rem_ff <= 8'd1) begin
                  rem_in   = '0;
                  phase_in = PH_LEAD;
               end else begin
                  rem_in = rem_ff - 8'd1;
               end
            end
         end
         PH_PAT_COUNT: begin
            if (b == 8'd0) err = ERR_VERTICAL;
            else if (13'(pos_ff) + 13'(b) * 13'(plen) > 13'(rlen)) err = ERR_OVERRUN;
            else begin
               rep_in   = b;
               fill_in  = '0;
               phase_in = PH_PAT_COUNT == phase_ff ? PH_PAT_DATA : phase_ff;
            end
         end
         PH_PAT_DATA: begin
            fill_in = fill_ff + PLEN_W'(1);
            if (fill_ff + PLEN_W'(1) >= plen) begin
               total_w   = 13'(rep_ff) * 13'(plen);
               emit_plen = plen;
               emit_pat  = pat_now;
               if (13'(pos_ff) + total_w > 13'(rlen)) err = ERR_OVERRUN;
               else emit = 1'b1;
               fill_in  = '0;
               rep_in   = '0;
               phase_in = PH_LEAD;
            end
         end
         default: begin
            phase_in = PH_LEAD;
         end
      endcase

      pos_after = 13'(pos_ff) + total_w;
      if (emit) begin
         if (pos_after == 13'(rlen)) pos_in = '0;
         else pos_in = pos_after[ROW_W-1:0];
      end

      // truncation: row not closed after the last available byte
      if (err == ERR_NONE && req_item.end_of_data &&
          (phase_in != PH_LEAD || pos_in != '0)) begin
         err = ERR_TRUNC;
      end

      if (err != ERR_NONE) begin
         phase_in = PH_LEAD;
         pos_in   = '0;
         rem_in   = '0;
         rep_in   = '0;
         fill_in  = '0;
      end
   end

   always_comb begin
      cmd.err       = err;
      cmd.total     = total_w[ROW_W-1:0];
      cmd.start_pos = pos_ff;
      cmd.rlen      = rlen;
      cmd.plen      = emit_plen;
      cmd.pattern   = emit_pat;
   end
   assign cmd_push = acc && (emit || err != ERR_NONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEAD;
         pos_ff   <= '0;
         rem_ff   <= '0;
         rep_ff   <= '0;
         fill_ff  <= '0;
      end else if (acc) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         rem_ff   <= rem_in;
         rep_ff   <= rep_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc && phase_ff == PH_PAT_DATA) begin
         store_ff[fill_ff[PIDX_W-1:0]] <= b;
      end
   end

endmodule

[rtl/rrd_cmdq.sv]
// ----------------------------------------------------------------------------
// rrd_cmdq
// two-entry queue of run commands between parser and expander
// ----------------------------------------------------------------------------
module rrd_cmdq (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rrd_pkg::cmd_type  push_cmd,
   output logic              full,
   input  logic              pop,
   output rrd_pkg::cmd_type  head,
   output logic              empty
);
   import rrd_pkg::*;

   cmd_type     slot_ff [2];
   logic        wr_ff, wr_in;
   logic        rd_ff, rd_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        do_push, do_pop;

   assign full    = cnt_ff == 2'd2;
   assign empty   = cnt_ff == 2'd0;
   assign head    = slot_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_in  = do_push ? !wr_ff : wr_ff;
      rd_in  = do_pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_cmd;
   end

endmodule

[rtl/rrd_back.sv]
// ----------------------------------------------------------------------------
// rrd_back
// expands run commands into words of up to eight bytes
// ----------------------------------------------------------------------------
module rrd_back (
   input  logic              clock,
   input  logic              reset,
   input  rrd_pkg::cmd_type  head,
   input  logic              q_empty,
   output logic              q_pop,
   output rrd_pkg::rsp_type  rsp_item,
   output logic              rsp_empty,
   input  logic              rsp_pop
);
   import rrd_pkg::*;

   logic               busy_ff, busy_in;
   cmd_type            cur_ff;
   logic [ROW_W-1:0]   remain_ff, remain_in;
   logic [ROW_W-1:0]   pos_ff, pos_in;
   logic [PIDX_W-1:0]  pidx_ff, pidx_in;
   rsp_type            out_ff, out_in;
   logic               valid_ff, valid_in;

   logic               slot_free;
   logic               fire;
   logic [3:0]         cnt;
   logic [ROW_W-1:0]   pos_next;
   logic [PLEN_W-1:0]  idx [WORD_BYTES+1];
   logic [63:0]        word;

   assign slot_free = !valid_ff || rsp_pop;
   assign fire      = busy_ff && slot_free;
   assign q_pop     = !busy_ff && !q_empty;
   assign rsp_item  = out_ff;
   assign rsp_empty = !valid_ff;

   always_comb begin
      cnt = (remain_ff >= ROW_W'(WORD_BYTES)) ? 4'(WORD_BYTES) : remain_ff[3:0];
      idx[0] = PLEN_W'(pidx_ff);
      for (int c = 0; c < WORD_BYTES; c++) begin
         if (idx[c] + PLEN_W'(1) == cur_ff.plen) idx[c+1] = '0;
         else idx[c+1] = idx[c] + PLEN_W'(1);
      end
      for (int c = 0; c < WORD_BYTES; c++) begin
         if (4'(c) < cnt) word[c*8 +: 8] = cur_ff.pattern[idx[c][PIDX_W-1:0]*8 +: 8];
         else word[c*8 +: 8] = 8'd0;
      end
      pos_next = pos_ff + ROW_W'(cnt);
   end

   always_comb begin
      busy_in   = busy_ff;
      remain_in = remain_ff;
      pos_in    = pos_ff;
      pidx_in   = pidx_ff;
      out_in    = out_ff;
      valid_in  = valid_ff && !rsp_pop;
      if (q_pop) begin
         busy_in   = 1'b1;
         remain_in = head.total;
         pos_in    = head.start_pos;
         pidx_in   = '0;
      end else if (fire) begin
         valid_in = 1'b1;
         if (cur_ff.err != ERR_NONE) begin
            out_in.out_bytes   = '0;
            out_in.byte_count  = '0;
            out_in.row_done    = 1'b0;
            out_in.error_code  = cur_ff.err;
            out_in.last_of_run = 1'b1;
            busy_in            = 1'b0;
         end else begin
            out_in.out_bytes   = word;
            out_in.byte_count  = cnt;
            out_in.row_done    = pos_next == cur_ff.rlen;
            out_in.error_code  = ERR_NONE;
            out_in.last_of_run = remain_ff == ROW_W'(cnt);
            busy_in            = remain_ff != ROW_W'(cnt);
            remain_in          = remain_ff - ROW_W'(cnt);
            pos_in             = pos_next;
            pidx_in            = idx[WORD_BYTES][PIDX_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) cur_ff <= head;
      remain_ff <= remain_in;
      pos_ff    <= pos_in;
      pidx_ff   <= pidx_in;
      out_ff    <= out_in;
   end

endmodule

[rtl/raster_row_rle_decoder.sv]
// ----------------------------------------------------------------------------
// raster_row_rle_decoder
// run-length decoder rebuilding one plane row from an encoded byte stream
// ----------------------------------------------------------------------------
// the parser takes one encoded item per cycle while its two-entry command
// queue has room; each item that completes a run (or hits an error) places
// one command in the queue. the expander turns a command into result words
// of up to eight bytes, one word per cycle while the output register is
// free, after loading the command from the queue into its own register.
// the input stalls only when the expander falls behind, so long runs (up to
// 64 words) throttle the input through the command queue. an output
// register holds the oldest result until it is popped. errors yield one
// result with zero byte_count and the decoder restarts at a new row.
module raster_row_rle_decoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  rrd_pkg::req_type   req_item,
   output logic               req_full,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output rrd_pkg::rsp_type   rsp_item,
   input  logic               csr_we,
   input  logic [0:0]         csr_index,
   input  logic [9:0]         csr_wdata
);
   import rrd_pkg::*;

   // configuration registers, taken raw; clamping happens in the parser
   logic [9:0]  row_length_ff;
   logic [4:0]  pattern_length_ff;

   cmd_type     cmd;
   cmd_type     head;
   logic        cmd_push;
   logic        cmd_full;
   logic        q_empty;
   logic        q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff     <= 10'd80;
         pattern_length_ff <= 5'd1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ROW_LENGTH:     row_length_ff     <= csr_wdata;
            CSR_PATTERN_LENGTH: pattern_length_ff <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // parser: classifies items and tracks row position
   rrd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_item       (req_item),
      .req_full       (req_full),
      .row_length     (row_length_ff),
      .pattern_length (pattern_length_ff),
      .cmd_push       (cmd_push),
      .cmd            (cmd),
      .cmd_full       (cmd_full)
   );

   // decoupling queue
   rrd_cmdq u_cmdq (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (cmd),
      .full     (cmd_full),
      .pop      (q_pop),
      .head     (head),
      .empty    (q_empty)
   );

   // expander: word generation and output register
   rrd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_item  (rsp_item),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

endmodule
